### rtl/core/oikp_pkg.sv
// Package: shared types, constants and trig table builder for the omni drive kinematics.
`timescale 1ns / 1ps
package oikp_pkg;

  localparam int VEL_W      = 16;
  localparam int YAW_W      = 12;
  localparam int DUTY_W     = 15;
  localparam int WHEELS     = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int RADIUS_W   = 16;
  localparam int LIMIT_W    = 15;
  localparam int SCALE_W    = 16;
  localparam int SPEED_W    = 18;

  localparam int YAW_FULL   = 3600;
  localparam int YAW_OFFSET = 450;
  localparam int QUAD_SPAN  = 900;
  localparam int TRIG_POINTS = 900;
  localparam int TRIG_W_MAX = 25;
  localparam int RIDX_W     = 10;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd22938;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd2617;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd17157;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_SCALE  = 2'd2
  } cfg_reg_t;

  localparam longint ONE_Q30 = longint'(1) << 30;
  localparam longint PI_Q30  = 64'sd3373259426;

  typedef logic [TRIG_W_MAX-1:0] trig_val_t;
  typedef trig_val_t trig_rom_t [TRIG_POINTS];

  typedef struct packed {
    logic [WHEELS-1:0][DUTY_W-1:0] fwd;
    logic [WHEELS-1:0][DUTY_W-1:0] rev;
    logic [WHEELS-1:0]             flags;
  } duty_t;

  function automatic longint to_trig(longint v, int frac);
    longint t;
    t = (v < 0) ? longint'(0) : v;
    return (t + (longint'(1) << (29 - frac))) >>> (30 - frac);
  endfunction

  // Horner-form Taylor series in Q2.30, evaluated at elaboration.
  function automatic trig_rom_t build_rom(int frac, bit want_cos);
    trig_rom_t rom;
    longint x, x2, ts, tc, v;
    for (int r = 0; r < TRIG_POINTS; r++) begin
      x  = (longint'(r) * PI_Q30) / 1800;
      x2 = (x * x) / ONE_Q30;
      ts = ONE_Q30;
      tc = ONE_Q30;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 156;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 110;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 72;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 42;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 20;
      ts = ONE_Q30 - ((x2 * ts) / ONE_Q30) / 6;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 132;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 90;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 56;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 30;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 12;
      tc = ONE_Q30 - ((x2 * tc) / ONE_Q30) / 2;
      v = want_cos ? to_trig(tc, frac) : to_trig((x * ts) / ONE_Q30, frac);
      rom[r] = trig_val_t'(v);
    end
    return rom;
  endfunction

endpackage

### rtl/core/oikp_cmd_if.sv
// Interface: velocity command channel.
`timescale 1ns / 1ps
interface oikp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [oikp_pkg::VEL_W-1:0]   vel_x;
  logic signed [oikp_pkg::VEL_W-1:0]   vel_y;
  logic signed [oikp_pkg::VEL_W-1:0]   vel_turn;
  logic        [oikp_pkg::YAW_W-1:0]   yaw_tenths;

  modport source (output valid, vel_x, vel_y, vel_turn, yaw_tenths, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_turn, yaw_tenths, output ready);
endinterface

### rtl/core/oikp_res_if.sv
// Interface: wheel duty result channel.
`timescale 1ns / 1ps
interface oikp_res_if;
  logic                               valid;
  logic                               ready;
  logic [oikp_pkg::DUTY_W-1:0]        fwd_duty_a;
  logic [oikp_pkg::DUTY_W-1:0]        fwd_duty_b;
  logic [oikp_pkg::DUTY_W-1:0]        fwd_duty_c;
  logic [oikp_pkg::DUTY_W-1:0]        fwd_duty_d;
  logic [oikp_pkg::DUTY_W-1:0]        rev_duty_a;
  logic [oikp_pkg::DUTY_W-1:0]        rev_duty_b;
  logic [oikp_pkg::DUTY_W-1:0]        rev_duty_c;
  logic [oikp_pkg::DUTY_W-1:0]        rev_duty_d;
  logic [oikp_pkg::WHEELS-1:0]        clamp_flags;

  modport source (output valid, fwd_duty_a, fwd_duty_b, fwd_duty_c, fwd_duty_d,
                  rev_duty_a, rev_duty_b, rev_duty_c, rev_duty_d, clamp_flags,
                  input ready);
  modport sink   (input valid, fwd_duty_a, fwd_duty_b, fwd_duty_c, fwd_duty_d,
                  rev_duty_a, rev_duty_b, rev_duty_c, rev_duty_d, clamp_flags,
                  output ready);
endinterface

### rtl/core/oikp_trig.sv
// Heading reduction, banked sin/cos table lookup and quadrant rotation (stages 1-3).
`timescale 1ns / 1ps
module oikp_trig #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic        [oikp_pkg::YAW_W-1:0]   yaw,
  input  logic signed [oikp_pkg::VEL_W-1:0]   vx,
  input  logic signed [oikp_pkg::VEL_W-1:0]   vy,
  input  logic signed [oikp_pkg::VEL_W-1:0]   vt,
  output logic signed [TRIG_FRAC_BITS+1:0]    sin_q,
  output logic signed [TRIG_FRAC_BITS+1:0]    cos_q,
  output logic signed [oikp_pkg::VEL_W-1:0]   vx_q,
  output logic signed [oikp_pkg::VEL_W-1:0]   vy_q,
  output logic signed [oikp_pkg::VEL_W-1:0]   vt_q
);
  localparam int TW = TRIG_FRAC_BITS + 1;
  localparam int SW = TRIG_FRAC_BITS + 2;
  localparam int AW = oikp_pkg::YAW_W + 1;
  localparam oikp_pkg::trig_rom_t SIN_ROM = oikp_pkg::build_rom(TRIG_FRAC_BITS, 1'b0);
  localparam oikp_pkg::trig_rom_t COS_ROM = oikp_pkg::build_rom(TRIG_FRAC_BITS, 1'b1);

  logic [oikp_pkg::YAW_W-1:0]  yaw_m;
  logic [AW-1:0]               ang_raw;
  logic [AW-1:0]               ang;
  logic [1:0]                  quad_next;
  logic [AW-1:0]               r_full;

  logic [1:0]                        quad1;
  logic [oikp_pkg::RIDX_W-1:0]       r1;
  logic signed [oikp_pkg::VEL_W-1:0] vx1, vy1, vt1;

  logic [1:0]                        quad2;
  logic [1:0]                        sel2;
  logic [3:0][TW-1:0]                sin_bank;
  logic [3:0][TW-1:0]                cos_bank;
  logic signed [oikp_pkg::VEL_W-1:0] vx2, vy2, vt2;

  logic signed [SW-1:0] s0, c0;

  always_comb begin
    yaw_m = (yaw >= oikp_pkg::YAW_W'(oikp_pkg::YAW_FULL))
          ? yaw - oikp_pkg::YAW_W'(oikp_pkg::YAW_FULL) : yaw;
    ang_raw = {1'b0, yaw_m} + AW'(oikp_pkg::YAW_OFFSET);
    ang = (ang_raw >= AW'(oikp_pkg::YAW_FULL))
        ? ang_raw - AW'(oikp_pkg::YAW_FULL) : ang_raw;
    priority if (ang < AW'(oikp_pkg::QUAD_SPAN)) begin
      quad_next = 2'd0;
      r_full = ang;
    end else if (ang < AW'(2 * oikp_pkg::QUAD_SPAN)) begin
      quad_next = 2'd1;
      r_full = ang - AW'(oikp_pkg::QUAD_SPAN);
    end else if (ang < AW'(3 * oikp_pkg::QUAD_SPAN)) begin
      quad_next = 2'd2;
      r_full = ang - AW'(2 * oikp_pkg::QUAD_SPAN);
    end else begin
      quad_next = 2'd3;
      r_full = ang - AW'(3 * oikp_pkg::QUAD_SPAN);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= quad_next;
      r1    <= r_full[oikp_pkg::RIDX_W-1:0];
      vx1   <= vx;
      vy1   <= vy;
      vt1   <= vt;
    end
  end

  // four banks interleaved on the low two index bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sin_bank[k] <= SIN_ROM[{r1[oikp_pkg::RIDX_W-1:2], 2'(k)}][TW-1:0];
        cos_bank[k] <= COS_ROM[{r1[oikp_pkg::RIDX_W-1:2], 2'(k)}][TW-1:0];
      end
      quad2 <= quad1;
      sel2  <= r1[1:0];
      vx2   <= vx1;
      vy2   <= vy1;
      vt2   <= vt1;
    end
  end

  assign s0 = signed'({1'b0, sin_bank[sel2]});
  assign c0 = signed'({1'b0, cos_bank[sel2]});

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad2)
        2'd0: begin sin_q <= s0;  cos_q <= c0;  end
        2'd1: begin sin_q <= c0;  cos_q <= -s0; end
        2'd2: begin sin_q <= -s0; cos_q <= -c0; end
        default: begin sin_q <= -c0; cos_q <= s0; end
      endcase
      vx_q <= vx2;
      vy_q <= vy2;
      vt_q <= vt2;
    end
  end
endmodule

### rtl/core/oikp_mix.sv
// Wheel mixing products, speed truncation, clamp and duty scaling (stages 4-8).
`timescale 1ns / 1ps
module oikp_mix #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [TRIG_FRAC_BITS+1:0]       sin_q,
  input  logic signed [TRIG_FRAC_BITS+1:0]       cos_q,
  input  logic signed [oikp_pkg::VEL_W-1:0]      vx,
  input  logic signed [oikp_pkg::VEL_W-1:0]      vy,
  input  logic signed [oikp_pkg::VEL_W-1:0]      vt,
  input  logic        [oikp_pkg::RADIUS_W-1:0]   radius,
  input  logic        [oikp_pkg::LIMIT_W-1:0]    limit,
  input  logic        [oikp_pkg::SCALE_W-1:0]    scale,
  output oikp_pkg::duty_t                        duty
);
  localparam int SW = TRIG_FRAC_BITS + 2;
  localparam int PW = SW + oikp_pkg::VEL_W;
  localparam int LW = PW + 1;
  localparam int TW = oikp_pkg::RADIUS_W + oikp_pkg::VEL_W + 1;
  localparam int NW = TRIG_FRAC_BITS + 35;
  localparam int DS = TRIG_FRAC_BITS + 16;
  localparam int SPW = oikp_pkg::SPEED_W;
  localparam int MW = oikp_pkg::LIMIT_W + oikp_pkg::SCALE_W;

  logic signed [PW-1:0] sx, cx, sy, cy;
  logic signed [TW-1:0] turn;

  logic signed [LW-1:0] lin_p, lin_q;
  logic signed [NW-1:0] sp, sq, st;
  logic signed [NW-1:0] num [oikp_pkg::WHEELS];

  logic signed [NW-1:0]  bias [oikp_pkg::WHEELS];
  logic signed [NW-1:0]  quo  [oikp_pkg::WHEELS];
  logic signed [SPW-1:0] speed [oikp_pkg::WHEELS];

  logic signed [SPW-1:0]            lim_s;
  logic [oikp_pkg::WHEELS-1:0][oikp_pkg::LIMIT_W-1:0] mag;
  logic [oikp_pkg::WHEELS-1:0]      pos, neg, flag;

  logic [MW-1:0] prod [oikp_pkg::WHEELS];

  always_ff @(posedge clk) begin
    if (en) begin
      sx   <= sin_q * PW'(vx);
      cx   <= cos_q * PW'(vx);
      sy   <= sin_q * PW'(vy);
      cy   <= cos_q * PW'(vy);
      turn <= signed'({1'b0, radius}) * TW'(vt);
    end
  end

  always_comb begin
    lin_p = LW'(cy) - LW'(sx);
    lin_q = LW'(cx) + LW'(sy);
    sp = NW'(lin_p) <<< 16;
    sq = NW'(lin_q) <<< 16;
    st = NW'(turn) <<< TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= st + sp;
      num[1] <= st - sq;
      num[2] <= st - sp;
      num[3] <= st + sq;
    end
  end

  // divide toward zero
  always_comb begin
    for (int w = 0; w < oikp_pkg::WHEELS; w++) begin
      bias[w] = num[w][NW-1] ? ((NW'(1) <<< DS) - NW'(1)) : '0;
      quo[w]  = (num[w] + bias[w]) >>> DS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < oikp_pkg::WHEELS; w++) begin
        speed[w] <= quo[w][SPW-1:0];
      end
    end
  end

  assign lim_s = signed'(SPW'(limit));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < oikp_pkg::WHEELS; w++) begin
        priority if (speed[w] > lim_s) begin
          mag[w]  <= limit;
          flag[w] <= 1'b1;
        end else if (speed[w] < -lim_s) begin
          mag[w]  <= limit;
          flag[w] <= 1'b1;
        end else begin
          mag[w]  <= speed[w][SPW-1] ? oikp_pkg::LIMIT_W'(-speed[w])
                                     : speed[w][oikp_pkg::LIMIT_W-1:0];
          flag[w] <= 1'b0;
        end
        pos[w] <= (speed[w] > 0) && (limit != '0);
        neg[w] <= (speed[w] < 0) && (limit != '0);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < oikp_pkg::WHEELS; w++) begin
      prod[w] = MW'(mag[w]) * MW'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < oikp_pkg::WHEELS; w++) begin
        duty.fwd[w] <= pos[w] ? prod[w][MW-1:16] : '0;
        duty.rev[w] <= neg[w] ? prod[w][MW-1:16] : '0;
      end
      duty.flags <= flag;
    end
  end
endmodule

### rtl/core/omni_inverse_kinematics_pwm.sv
// Top level: four-wheel omni X-drive inverse kinematics with H-bridge duty outputs.
// 8-stage pipeline from command transaction to result valid.
// Throughput: one transaction per cycle; a stalled result halts every stage together.
// Reset clears the stage valid bits and loads the configuration defaults.
// Sin/cos come from a 900-point table split in four banks.
`timescale 1ns / 1ps
module omni_inverse_kinematics_pwm #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  oikp_cmd_if.sink                             cmd,
  oikp_res_if.source                           res,
  input  logic                                 cfg_we,
  input  logic [oikp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [oikp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int STAGES = 8;

  logic [oikp_pkg::RADIUS_W-1:0] wheel_radius_q16;
  logic [oikp_pkg::LIMIT_W-1:0]  speed_limit;
  logic [oikp_pkg::SCALE_W-1:0]  pwm_scale_q16;

  logic                 en;
  logic [STAGES-1:0]    vld;

  logic signed [TRIG_FRAC_BITS+1:0]     sin_q, cos_q;
  logic signed [oikp_pkg::VEL_W-1:0]    vx3, vy3, vt3;
  oikp_pkg::duty_t                      duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius_q16 <= oikp_pkg::RADIUS_RESET;
      speed_limit      <= oikp_pkg::LIMIT_RESET;
      pwm_scale_q16    <= oikp_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        oikp_pkg::REG_RADIUS: wheel_radius_q16 <= cfg_data;
        oikp_pkg::REG_LIMIT:  speed_limit      <= cfg_data[oikp_pkg::LIMIT_W-1:0];
        oikp_pkg::REG_SCALE:  pwm_scale_q16    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !res.valid || res.ready;
  assign cmd.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], cmd.valid};
    end
  end

  oikp_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .clk   (clk),
    .en    (en),
    .yaw   (cmd.yaw_tenths),
    .vx    (cmd.vel_x),
    .vy    (cmd.vel_y),
    .vt    (cmd.vel_turn),
    .sin_q (sin_q),
    .cos_q (cos_q),
    .vx_q  (vx3),
    .vy_q  (vy3),
    .vt_q  (vt3)
  );

  oikp_mix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mix (
    .clk    (clk),
    .en     (en),
    .sin_q  (sin_q),
    .cos_q  (cos_q),
    .vx     (vx3),
    .vy     (vy3),
    .vt     (vt3),
    .radius (wheel_radius_q16),
    .limit  (speed_limit),
    .scale  (pwm_scale_q16),
    .duty   (duty)
  );

  assign res.valid       = vld[STAGES-1];
  assign res.fwd_duty_a  = duty.fwd[0];
  assign res.fwd_duty_b  = duty.fwd[1];
  assign res.fwd_duty_c  = duty.fwd[2];
  assign res.fwd_duty_d  = duty.fwd[3];
  assign res.rev_duty_a  = duty.rev[0];
  assign res.rev_duty_b  = duty.rev[1];
  assign res.rev_duty_c  = duty.rev[2];
  assign res.rev_duty_d  = duty.rev[3];
  assign res.clamp_flags = duty.flags;

`ifndef SYNTH
  a_no_valid_after_reset: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_one_side_driven: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !((duty.fwd[0] != '0 && duty.rev[0] != '0) ||
                    (duty.fwd[1] != '0 && duty.rev[1] != '0) ||
                    (duty.fwd[2] != '0 && duty.rev[2] != '0) ||
                    (duty.fwd[3] != '0 && duty.rev[3] != '0)))
    else $error("forward and reverse duty both nonzero");

  a_limit_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == oikp_pkg::REG_LIMIT) |=>
      speed_limit == $past(cfg_data[oikp_pkg::LIMIT_W-1:0]))
    else $error("speed limit write lost");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> $stable(vld))
    else $error("pipeline moved during stall");
`endif
endmodule
